// File: sv/msort_pkg.sv
`default_nettype none
package msort_pkg;

	localparam int unsigned DATA_W           = 32;
	localparam int unsigned MAX_ELEMENTS_DEF = 64;

	// Payload of one input word.
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} msort_in_t;

	// Payload of one result word.
	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     final_res;
		logic                     overflow;
	} msort_out_t;

	// Operands of one merge step: the two run heads and whether each run still has data.
	typedef struct packed {
		logic signed [DATA_W-1:0] left_head;
		logic signed [DATA_W-1:0] right_head;
		logic                     left_ok;
		logic                     right_ok;
	} msort_step_in_t;

	// Outcome of one merge step.
	typedef struct packed {
		logic                     take_left;
		logic signed [DATA_W-1:0] value;
	} msort_step_out_t;

endpackage
`default_nettype wire

// File: sv/msort_if.sv
`default_nettype none
interface msort_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/msort_ram.sv
`default_nettype none
module msort_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: sv/msort_merge_step.sv
`default_nettype none
module msort_merge_step (
	input  wire msort_pkg::msort_step_in_t  step_in,
	output msort_pkg::msort_step_out_t      step_out
);
	import msort_pkg::*;

	// The left head wins unless the right one is strictly smaller, which keeps the merge stable.
	always_comb begin
		step_out.take_left = step_in.left_ok &&
			(!step_in.right_ok || !(step_in.right_head < step_in.left_head));
		step_out.value = step_out.take_left ? step_in.left_head : step_in.right_head;
	end
endmodule
`default_nettype wire

// File: sv/merge_sorter.sv
// Loading: the block accepts words back to back while it is collecting a run.
// Sorting: ceil(log2 N) passes over the run, each a series of block pairs, each pair set up in
// S_PASS and S_PRE and then merged in S_MERGE (a lone tail block is copied as a pair with an empty
// right run); a last visit to S_PASS sees that the passes are done. One shared compare/select
// step writes one element per cycle in S_MERGE.
// Emitting: each result is read in S_ORD and loaded into the output register in S_OWAIT when free.
// Reset (arst_n low, asynchronous) empties the run and the output register; memories keep data.
`default_nettype none
module merge_sorter #(
	parameter int unsigned MAX_ELEMENTS = msort_pkg::MAX_ELEMENTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	msort_if.sink    elem,
	msort_if.source  sorted
);
	import msort_pkg::*;

	localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
	// Block bounds lo + 2 * width need headroom beyond the element count.
	localparam int unsigned LW = CW + 2;

	typedef enum logic [5:0] {
		S_LOAD  = 6'b000001,
		S_PASS  = 6'b000010,
		S_PRE   = 6'b000100,
		S_MERGE = 6'b001000,
		S_ORD   = 6'b010000,
		S_OWAIT = 6'b100000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;      // elements in the run, also N while sorting
	logic            drop_q;     // a word was dropped in this run
	logic [LW-1:0]   w_q;        // run width of the current pass
	logic [CW-1:0]   lo_q;       // start of the current block pair
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   j_q;
	logic [CW-1:0]   k_q;
	logic [CW-1:0]   mid_q;
	logic [CW-1:0]   hi_q;
	logic            src_q;      // buffer that holds the current runs
	logic            pend_r_q;   // read data this cycle is the right head
	logic [DATA_W-1:0] hl_q;
	logic [DATA_W-1:0] hr_q;
	logic            ov_q;
	msort_out_t      out_q;

	logic [DATA_W-1:0] rd0;
	logic [DATA_W-1:0] rd1;
	logic [DATA_W-1:0] rd_data;
	logic [AW-1:0]     rd_addr;
	logic              we0;
	logic              we1;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;

	msort_step_in_t    step_in;
	msort_step_out_t   step_out;

	logic              in_acc;
	logic              room;
	logic [LW-1:0]     n_l;
	logic [LW-1:0]     lo_w;
	logic [LW-1:0]     lo_2w;
	logic [CW-1:0]     mid_c;
	logic [CW-1:0]     hi_c;
	logic [CW-1:0]     i_inc;
	logic [CW-1:0]     j_inc;
	logic [CW-1:0]     k_inc;
	logic              last_word;
	logic              out_load;

	assign elem.ready   = (state_q == S_LOAD);
	assign sorted.valid = ov_q;
	assign sorted.data  = out_q;

	assign in_acc  = elem.valid && elem.ready;
	assign room    = (cnt_q < CW'(MAX_ELEMENTS));
	assign rd_data = src_q ? rd1 : rd0;

	// Block pair bounds: [lo, mid) and [mid, hi), both clamped to the run length.
	assign n_l   = LW'(cnt_q);
	assign lo_w  = LW'(lo_q) + w_q;
	assign lo_2w = lo_w + w_q;
	assign mid_c = (lo_w  > n_l) ? cnt_q : lo_w[CW-1:0];
	assign hi_c  = (lo_2w > n_l) ? cnt_q : lo_2w[CW-1:0];

	assign i_inc = i_q + 1'b1;
	assign j_inc = j_q + 1'b1;
	assign k_inc = k_q + 1'b1;

	assign last_word = (k_inc == cnt_q);
	assign out_load  = (state_q == S_OWAIT) && (!ov_q || sorted.ready);

	// The head consumed in the last step is refilled by this cycle's read data.
	always_comb begin
		step_in.left_head  = pend_r_q ? hl_q    : rd_data;
		step_in.right_head = pend_r_q ? rd_data : hr_q;
		step_in.left_ok    = (i_q < mid_q);
		step_in.right_ok   = (j_q < hi_q);
	end

	msort_merge_step u_step (
		.step_in  (step_in),
		.step_out (step_out)
	);

	// One read address for both buffers; the source buffer select picks the data.
	always_comb begin
		unique case (state_q)
			S_LOAD:  rd_addr = '0;
			S_PASS:  rd_addr = lo_q[AW-1:0];
			S_PRE:   rd_addr = mid_q[AW-1:0];
			S_MERGE: rd_addr = step_out.take_left ? i_inc[AW-1:0] : j_inc[AW-1:0];
			S_ORD:   rd_addr = k_q[AW-1:0];
			S_OWAIT: rd_addr = k_q[AW-1:0];
			default: rd_addr = '0;
		endcase
	end

	// Loading fills buffer 0; each merge pass writes the buffer that is not the source.
	always_comb begin
		if (state_q == S_LOAD) begin
			we0   = in_acc && room;
			we1   = 1'b0;
			waddr = cnt_q[AW-1:0];
			wdata = elem.data.value;
		end else begin
			we0   = (state_q == S_MERGE) && src_q;
			we1   = (state_q == S_MERGE) && !src_q;
			waddr = k_q[AW-1:0];
			wdata = step_out.value;
		end
	end

	msort_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_ELEMENTS)
	) u_buf0 (
		.clk     (clk),
		.we      (we0),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (rd_addr),
		.rdata_q (rd0)
	);

	msort_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_ELEMENTS)
	) u_buf1 (
		.clk     (clk),
		.we      (we1),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (rd_addr),
		.rdata_q (rd1)
	);

	// Sequencer: collect, then merge passes of doubling width, then read out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			cnt_q    <= '0;
			drop_q   <= 1'b0;
			w_q      <= LW'(1);
			lo_q     <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			mid_q    <= '0;
			hi_q     <= '0;
			src_q    <= 1'b0;
			pend_r_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (room) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
						if (elem.data.last) begin
							lo_q    <= '0;
							state_q <= S_PASS;
						end
					end
				end
				S_PASS: begin
					if (w_q >= n_l) begin
						k_q     <= '0;
						state_q <= S_ORD;
					end else begin
						i_q     <= lo_q;
						j_q     <= mid_c;
						k_q     <= lo_q;
						mid_q   <= mid_c;
						hi_q    <= hi_c;
						state_q <= S_PRE;
					end
				end
				S_PRE: begin
					pend_r_q <= 1'b1;
					state_q  <= S_MERGE;
				end
				S_MERGE: begin
					k_q <= k_inc;
					if (step_out.take_left) begin
						i_q      <= i_inc;
						pend_r_q <= 1'b0;
					end else begin
						j_q      <= j_inc;
						pend_r_q <= 1'b1;
					end
					if (k_inc == hi_q) begin
						if (lo_2w >= n_l) begin
							w_q   <= w_q << 1;
							src_q <= !src_q;
							lo_q  <= '0;
						end else begin
							lo_q <= lo_2w[CW-1:0];
						end
						state_q <= S_PASS;
					end
				end
				S_ORD: begin
					state_q <= S_OWAIT;
				end
				S_OWAIT: begin
					if (out_load) begin
						if (last_word) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							w_q     <= LW'(1);
							src_q   <= 1'b0;
							lo_q    <= '0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_inc;
							state_q <= S_ORD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (sorted.ready) begin
			ov_q <= 1'b0;
		end
	end

	// Run heads and the output word carry data only.
	always_ff @(posedge clk) begin
		if (state_q == S_PRE) begin
			hl_q <= rd_data;
		end else if (state_q == S_MERGE) begin
			hl_q <= step_in.left_head;
			hr_q <= step_in.right_head;
		end
		if (out_load) begin
			out_q.sorted_value <= rd_data;
			out_q.final_res    <= last_word;
			out_q.overflow     <= drop_q;
		end
	end
endmodule
`default_nettype wire

// File: sv/msort_checker.sv
`default_nettype none
module msort_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  in_last,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire msort_pkg::msort_out_t out_data
);
	import msort_pkg::*;

	// A stalled result word keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// A word marked last ends collection and starts the sort.
	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input still ready after last word");

	// While a run is being emitted no new word is taken.
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.final_res |-> !in_ready)
		else $error("input ready in the middle of a run");

	// A result word still pending while collecting must be the final word of the previous run.
	a_ready_final: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> out_data.final_res)
		else $error("idle with a non-final result pending");
endmodule

bind merge_sorter msort_checker u_msort_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (elem.valid),
	.in_ready  (elem.ready),
	.in_last   (elem.data.last),
	.out_valid (sorted.valid),
	.out_ready (sorted.ready),
	.out_data  (sorted.data)
);
`default_nettype wire

// File: dv/merge_sort_checker.sv
`timescale 1ns / 1ps
module merge_sort_checker #(
	parameter int unsigned DEPTH = msort_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  msort_pkg::msort_in_t  in_word,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  msort_pkg::msort_out_t out_word,
	output int unsigned           failures,
	output int unsigned           pending
);
	import msort_pkg::*;

	// Elements kept so far in the current run, and whether any were dropped.
	logic signed [DATA_W-1:0] run_vals[$];
	bit                       run_dropped;
	// Sorted words still owed by the block, oldest first.
	msort_out_t               owed_words[$];
	int unsigned              fail_cnt = 0;

	// Stable insertion sort of the run, then one owed word per kept element.
	function automatic void close_run();
		logic signed [DATA_W-1:0] key;
		msort_out_t w;
		int i;
		int j;
		for (i = 1; i < run_vals.size(); i++) begin
			key = run_vals[i];
			j = i;
			while (j > 0 && run_vals[j-1] > key) begin
				run_vals[j] = run_vals[j-1];
				j--;
			end
			run_vals[j] = key;
		end
		for (i = 0; i < run_vals.size(); i++) begin
			w.sorted_value = run_vals[i];
			w.final_res    = (i == run_vals.size() - 1);
			w.overflow     = run_dropped;
			owed_words.push_back(w);
		end
		run_vals.delete();
		run_dropped = 1'b0;
	endfunction

	function automatic void check_field(string name, logic signed [DATA_W-1:0] want,
		logic signed [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
			fail_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		msort_out_t want;
		if (!arst_n) begin
			run_vals.delete();
			run_dropped = 1'b0;
			owed_words.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (owed_words.size() == 0) begin
					$display("%0t: unexpected sorted word, got %0d", $time,
						$signed(out_word.sorted_value));
					fail_cnt++;
				end else begin
					want = owed_words.pop_front();
					check_field("sorted_value", want.sorted_value, out_word.sorted_value);
					check_field("final_res", want.final_res, out_word.final_res);
					check_field("overflow", want.overflow, out_word.overflow);
				end
			end
			if (in_valid && in_ready) begin
				if (run_vals.size() < DEPTH)
					run_vals.push_back(in_word.value);
				else
					run_dropped = 1'b1;
				if (in_word.last)
					close_run();
			end
		end
		failures <= fail_cnt;
		pending  <= owed_words.size();
	end
endmodule

// File: dv/tb_merge_sorter.sv
`timescale 1ns / 1ps
module tb_merge_sorter;
	import msort_pkg::*;

	localparam int unsigned STORE_DEPTH  = MAX_ELEMENTS_DEF;
	// Random words to send after the directed and boundary runs.
	localparam int unsigned RANDOM_WORDS = 30;
	// A full 64-element sort runs with nothing moving on either channel, so the
	// watchdog limit must exceed the length of such a sort.
	localparam int unsigned STALL_LIMIT  = 5000;
	// Quiet time after the last owed word, to catch anything extra.
	localparam int unsigned TAIL_CYCLES  = 100;

	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	logic        clk = 1'b0;
	logic        arst_n;
	// While set, neither the sender nor the receiver inserts idle cycles.
	logic        quiet;
	int unsigned idle_cycles = 0;
	int unsigned failures;
	int unsigned pending;

	msort_if #(.payload_t(msort_in_t))  elem_ch ();
	msort_if #(.payload_t(msort_out_t)) sorted_ch ();

	merge_sorter #(.MAX_ELEMENTS(STORE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.elem(elem_ch),
		.sorted(sorted_ch)
	);

	// The checker sees both channels, predicts the sorted runs and counts failures.
	merge_sort_checker #(.DEPTH(STORE_DEPTH)) sort_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(elem_ch.valid),
		.in_ready(elem_ch.ready),
		.in_word(elem_ch.data),
		.out_valid(sorted_ch.valid),
		.out_ready(sorted_ch.ready),
		.out_word(sorted_ch.data),
		.failures(failures),
		.pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The receiver stalls in about ten percent of cycles, independent of what the
	// block is doing, so stalls land on the first, middle and final word of runs.
	always @(posedge clk)
		sorted_ch.ready <= quiet || ($urandom_range(0, 99) >= 10);

	// Watchdog: any cycle in which some word moves restarts the count.
	always @(posedge clk) begin
		if ((elem_ch.valid && elem_ch.ready) || (sorted_ch.valid && sorted_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offers one word and returns at the edge where it is taken. Idle cycles come
	// first, so valid is only ever raised or lowered once per edge.
	task automatic send_word(input logic signed [DATA_W-1:0] v, input logic is_last);
		msort_in_t w;
		while (!quiet && $urandom_range(0, 99) < 10) begin
			elem_ch.valid <= 1'b0;
			@(posedge clk);
		end
		w.value = v;
		w.last  = is_last;
		elem_ch.valid <= 1'b1;
		elem_ch.data  <= w;
		@(posedge clk);
		while (!elem_ch.ready)
			@(posedge clk);
	endtask

	// A mix of full-range values, a narrow band that makes many equal keys, and
	// the extremes of the signed range, zero and minus one.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $signed($urandom_range(0, 8)) - 4;
			1: begin
				case ($urandom_range(0, 3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Sends a run of random values; only the final word carries last.
	task automatic send_run(input int unsigned len);
		int unsigned k;
		for (k = 0; k < len; k++)
			send_word(pick_value(), k == len - 1);
	endtask

	// Holds the sender off until the block has delivered every owed word. The
	// first edge lets the checker's count catch up with the word just taken.
	task automatic wait_for_results();
		elem_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned sent;
		int unsigned len;
		arst_n          = 1'b0;
		quiet           = 1'b0;
		elem_ch.valid   = 1'b0;
		elem_ch.data    = '0;
		sorted_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A run of a single element, which is already sorted.
		send_word(VAL_MIN, 1'b1);
		// Both extremes twice, zero and the values next to it, in scrambled order.
		send_word(VAL_MAX, 1'b0);
		send_word(VAL_MIN, 1'b0);
		send_word('0, 1'b0);
		send_word('1, 1'b0);
		send_word(1, 1'b0);
		send_word(VAL_MAX, 1'b0);
		send_word(VAL_MIN, 1'b1);
		// Repeated keys on both sides of zero.
		send_word(5, 1'b0);
		send_word(-5, 1'b0);
		send_word(5, 1'b0);
		send_word(-5, 1'b0);
		send_word(5, 1'b1);
		// Two equal elements, the smallest run that needs a merge.
		send_word('0, 1'b0);
		send_word('0, 1'b1);
		wait_for_results();

		// Store boundary, sent with no idling on either side: the
		// store fills, then a plain word and the word that carries last are both
		// dropped, and the kept elements are still sorted and flagged.
		quiet <= 1'b1;
		send_run(STORE_DEPTH + 2);
		quiet <= 1'b0;

		// Random runs, mostly short, with the odd long one. Now and then the
		// sender waits for the block to empty so that runs start both from idle
		// and back to back.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(20, STORE_DEPTH);
			else
				len = $urandom_range(1, 8);
			send_run(len);
			sent += len;
			if ($urandom_range(0, 7) == 0)
				wait_for_results();
		end

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// File: merge_sorter.f
sv/msort_pkg.sv
sv/msort_if.sv
sv/msort_ram.sv
sv/msort_merge_step.sv
sv/merge_sorter.sv
sv/msort_checker.sv
dv/merge_sort_checker.sv
dv/tb_merge_sorter.sv
